>>> hw/rtl/ddcs_pkg.sv
// shared types, codes and helpers for the differential drive command sequencer
package ddcs_pkg;

	localparam int unsigned SpeedW = 15;
	localparam int unsigned DriveW = 16;
	localparam int unsigned DurW   = 16;
	localparam int unsigned QDepth = 2;
	localparam int unsigned QPtrW  = $clog2(QDepth);
	localparam int unsigned QCntW  = $clog2(QDepth + 1);

	typedef enum logic [1:0] {
		MODE_CMD   = 2'd0,
		MODE_TICK  = 2'd1,
		MODE_ESTOP = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		CMD_STOP     = 3'd0,
		CMD_FORWARD  = 3'd1,
		CMD_BACKWARD = 3'd2,
		CMD_LEFT     = 3'd3,
		CMD_RIGHT    = 3'd4,
		CMD_ROTATE   = 3'd5
	} cmd_t;

	typedef enum logic {
		REG_MAX_SPEED     = 1'b0,
		REG_DEFAULT_SPEED = 1'b1
	} reg_idx_t;

	// classified operation handed from front to back
	typedef enum logic [2:0] {
		OP_SET,
		OP_KEEP,
		OP_TICK,
		OP_ESTOP,
		OP_NOP
	} op_kind_t;

	typedef struct packed {
		logic [1:0]               mode;
		logic [2:0]               cmd;
		logic signed [DriveW-1:0] speed;
		logic signed [15:0]       angle;
		logic [DurW-1:0]          run_ms;
	} item_t;

	typedef struct packed {
		logic signed [DriveW-1:0] left_drive;
		logic signed [DriveW-1:0] right_drive;
		logic                     moving;
		logic                     motion_complete;
	} result_t;

	typedef struct packed {
		op_kind_t                 kind;
		logic signed [DriveW-1:0] left;
		logic signed [DriveW-1:0] right;
		logic [DurW-1:0]          dur;
	} op_t;

	// clamp a 17-bit signed drive to +/- lim
	function automatic logic signed [DriveW-1:0] clamp_drive(
		input logic signed [DriveW:0] v,
		input logic [SpeedW-1:0]      lim
	);
		logic signed [DriveW:0] hi;
		logic signed [DriveW:0] lo;
		logic signed [DriveW:0] r;
		hi = signed'({2'b00, lim});
		lo = -hi;
		if (v > hi) begin
			r = hi;
		end else if (v < lo) begin
			r = lo;
		end else begin
			r = v;
		end
		return r[DriveW-1:0];
	endfunction

endpackage

>>> hw/rtl/ddcs_front.sv
// front end: configuration registers, item decode and drive target computation
module ddcs_front import ddcs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_idx,
	input  logic [SpeedW-1:0] cfg_data,
	input  item_t             item,
	output op_t               op
);

	logic [SpeedW-1:0] max_speed_q;
	logic [SpeedW-1:0] default_speed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q     <= SpeedW'(32767);
			default_speed_q <= SpeedW'(16384);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_MAX_SPEED:     max_speed_q     <= cfg_data;
				REG_DEFAULT_SPEED: default_speed_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic signed [DriveW:0] spd;
	logic signed [DriveW:0] spd_neg;
	logic signed [DriveW:0] spd_half;
	logic signed [DriveW-1:0] c_pos;
	logic signed [DriveW-1:0] c_neg;
	logic signed [DriveW-1:0] c_half;

	always_comb begin
		spd      = (item.speed == '0) ? signed'({2'b00, default_speed_q})
		                              : signed'({item.speed[DriveW-1], item.speed});
		spd_neg  = -spd;
		// add one for negatives so the shift truncates toward zero
		spd_half = (spd + signed'({{DriveW{1'b0}}, spd[DriveW]})) >>> 1;
		c_pos    = clamp_drive(spd, max_speed_q);
		c_neg    = clamp_drive(spd_neg, max_speed_q);
		c_half   = clamp_drive(spd_half, max_speed_q);
	end

	always_comb begin
		op.kind  = OP_NOP;
		op.left  = '0;
		op.right = '0;
		op.dur   = item.run_ms;
		unique case (mode_t'(item.mode))
			MODE_CMD: begin
				op.kind = OP_SET;
				unique case (cmd_t'(item.cmd))
					CMD_STOP: begin
						op.left  = '0;
						op.right = '0;
					end
					CMD_FORWARD: begin
						op.left  = c_pos;
						op.right = c_pos;
					end
					CMD_BACKWARD: begin
						op.left  = c_neg;
						op.right = c_neg;
					end
					CMD_LEFT: begin
						op.left  = c_half;
						op.right = c_pos;
					end
					CMD_RIGHT: begin
						op.left  = c_pos;
						op.right = c_half;
					end
					CMD_ROTATE: begin
						if (item.angle > 0) begin
							op.left  = c_pos;
							op.right = c_neg;
						end else begin
							op.left  = c_neg;
							op.right = c_pos;
						end
					end
					default: op.kind = OP_KEEP;
				endcase
			end
			MODE_TICK:  op.kind = OP_TICK;
			MODE_ESTOP: op.kind = OP_ESTOP;
			default:    op.kind = OP_NOP;
		endcase
	end

endmodule

>>> hw/rtl/ddcs_queue.sv
// short operation queue between front and back
module ddcs_queue import ddcs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  op_t  wr_op,
	output logic full,
	input  logic rd_en,
	output op_t  rd_op,
	output logic empty
);

	op_t              mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (cnt_q == QCntW'(QDepth));
	assign empty = (cnt_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_op = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> hw/rtl/ddcs_back.sv
// back end: drive and timer state, result queue
module ddcs_back import ddcs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  op_t     op,
	input  logic    op_valid,
	output logic    op_take,
	output result_t result,
	output logic    empty,
	input  logic    pop
);

	logic signed [DriveW-1:0] left_q;
	logic signed [DriveW-1:0] right_q;
	logic [DurW-1:0]          rem_q;

	result_t          res_mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] cnt_q;

	logic                     res_full;
	logic                     do_pop;
	logic signed [DriveW-1:0] left_d;
	logic signed [DriveW-1:0] right_d;
	logic [DurW-1:0]          rem_d;
	logic                     done_d;
	result_t                  res_d;

	assign res_full = (cnt_q == QCntW'(QDepth));
	assign empty    = (cnt_q == '0);
	assign do_pop   = pop && !empty;
	assign op_take  = op_valid && !res_full;
	assign result   = res_mem_q[rd_ptr_q];

	always_comb begin
		left_d  = left_q;
		right_d = right_q;
		rem_d   = rem_q;
		done_d  = 1'b0;
		unique case (op.kind)
			OP_SET: begin
				left_d  = op.left;
				right_d = op.right;
				rem_d   = op.dur;
			end
			OP_KEEP: rem_d = op.dur;
			OP_TICK: begin
				if (rem_q != '0) begin
					rem_d = rem_q - 1'b1;
					// timer expiry
					if (rem_q == DurW'(1)) begin
						left_d  = '0;
						right_d = '0;
						done_d  = 1'b1;
					end
				end
			end
			OP_ESTOP: begin
				left_d  = '0;
				right_d = '0;
				rem_d   = '0;
			end
			default: ;
		endcase
		res_d.left_drive      = left_d;
		res_d.right_drive     = right_d;
		res_d.moving          = (left_d != '0) || (right_d != '0);
		res_d.motion_complete = done_d;
	end

	always_ff @(posedge clk) begin
		if (op_take) begin
			res_mem_q[wr_ptr_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			right_q  <= '0;
			rem_q    <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (op_take) begin
				left_q   <= left_d;
				right_q  <= right_d;
				rem_q    <= rem_d;
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({op_take, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCntW'(QDepth))
		else $error("result queue count overflow");

	a_expire_stops: assert property (@(posedge clk) disable iff (!arst_n)
		op_take && done_d |=> left_q == '0 && right_q == '0 && rem_q == '0)
		else $error("timer expiry left drives or timer active");

	a_estop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		op_take && op.kind == OP_ESTOP |=> !res_mem_q[$past(wr_ptr_q)].moving)
		else $error("emergency stop result shows motion");

	a_no_take_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!op_take |=> $stable(left_q) && $stable(right_q) && $stable(rem_q))
		else $error("state changed without a transfer");

endmodule

>>> hw/rtl/differential_drive_command_sequencer.sv
// top level: differential drive command sequencer
// Each accepted item (motion command, millisecond tick or emergency stop) yields
// exactly one result showing the wheel drives now applied. An item is decoded
// and its clamped drive targets formed in the same cycle it is pushed; it then
// waits in a two-entry operation queue, and the back end applies it to the
// drive and timer state and writes the result into a two-entry result queue.
// Sustained rate is one item per clock while results are popped; a full result
// queue stalls the back end. Configuration writes take effect for commands
// pushed afterwards and are expected only while idle.
module differential_drive_command_sequencer import ddcs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_idx,
	input  logic [SpeedW-1:0] cfg_data,
	input  logic              push,
	input  item_t             item,
	output logic              full,
	input  logic              pop,
	output result_t           result,
	output logic              empty
);

	op_t  front_op;
	op_t  queue_op;
	logic queue_empty;
	logic back_take;

	ddcs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.item     (item),
		.op       (front_op)
	);

	ddcs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_op  (front_op),
		.full   (full),
		.rd_en  (back_take),
		.rd_op  (queue_op),
		.empty  (queue_empty)
	);

	ddcs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (queue_op),
		.op_valid (!queue_empty),
		.op_take  (back_take),
		.result   (result),
		.empty    (empty),
		.pop      (pop)
	);

endmodule
